>>> src/mcss_pkg.sv
// Shared types and constants for the Markov chain state sampler.
// No dependencies; every other file in src refers to it by scoped names.
`default_nettype none

package mcss_pkg;

   // Fixed field widths
   localparam int PROB_W     = 16;
   localparam int LEVEL_W    = 16;
   localparam int ROW_W      = 4;
   localparam int OUT_IDX_W  = 4;
   localparam int USED_W     = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [USED_W-1:0] USED_RESET = 5'd16;

   // Command codes of the request channel
   typedef enum logic [1:0] {
      CMD_LOAD_PROB  = 2'd0,
      CMD_LOAD_LEVEL = 2'd1,
      CMD_RESTART    = 2'd2,
      CMD_STEP       = 2'd3
   } cmd_type;

   // Register indexes of the CSR channel
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INITIAL_VALUE = 1'd0,
      CSR_STATES_IN_USE = 1'd1
   } csr_idx_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_LEVEL,
      ST_SEND
   } fsm_type;

   // Controller to datapath
   typedef struct packed {
      logic load_prob;
      logic load_level;
      logic start;
      logic zero_start;
      logic walk_en;
      logic level_rd;
      logic send;
   } ctrl_type;

   // Datapath to controller
   typedef struct packed {
      logic zero_u;
      logic walk_done;
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

>>> src/mcss_if.sv
// Valid/ready channel interfaces: request, response and CSR write.
// Depends on mcss_pkg for field widths.
`default_nettype none

interface mcss_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    command;
   logic [mcss_pkg::ROW_W-1:0]    row;
   logic [mcss_pkg::ROW_W-1:0]    column;
   logic [mcss_pkg::PROB_W-1:0]   probability;
   logic [mcss_pkg::LEVEL_W-1:0]  level;
   logic [mcss_pkg::PROB_W-1:0]   uniform;

   modport source (output valid, command, row, column, probability, level, uniform,
                   input ready);
   modport sink (input valid, command, row, column, probability, level, uniform,
                 output ready);
endinterface

interface mcss_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [mcss_pkg::OUT_IDX_W-1:0]   state_index;
   logic [mcss_pkg::LEVEL_W-1:0]     state_level;
   logic                             fell_short;

   modport source (output valid, state_index, state_level, fell_short, input ready);
   modport sink (input valid, state_index, state_level, fell_short, output ready);
endinterface

interface mcss_csr_if;
   logic                              valid;
   logic                              ready;
   logic [mcss_pkg::CSR_IDX_W-1:0]    index;
   logic [mcss_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/mcss_ctrl.sv
// Sequencing state machine of the sampler: accepts requests and steps the
// datapath through walk, level read and send. Depends on mcss_pkg.
`default_nettype none

module mcss_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic [1:0]         req_command,
   output logic                    req_ready,
   input  wire mcss_pkg::stat_type stat,
   output mcss_pkg::ctrl_type      ctrl
);

   mcss_pkg::fsm_type state_ff;
   mcss_pkg::fsm_type state_in;
   mcss_pkg::cmd_type cmd;

   assign cmd = mcss_pkg::cmd_type'(req_command);

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mcss_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      ctrl      = '0;
      req_ready = 1'b0;
      case (state_ff)
         mcss_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (cmd)
                  mcss_pkg::CMD_LOAD_PROB:  ctrl.load_prob  = 1'b1;
                  mcss_pkg::CMD_LOAD_LEVEL: ctrl.load_level = 1'b1;
                  mcss_pkg::CMD_STEP: begin
                     ctrl.start = 1'b1;
                     if (stat.zero_u) begin
                        ctrl.zero_start = 1'b1;
                        state_in        = mcss_pkg::ST_LEVEL;
                     end else begin
                        state_in = mcss_pkg::ST_WALK;
                     end
                  end
                  default: begin
                     ctrl.start = 1'b1;
                     state_in   = mcss_pkg::ST_WALK;
                  end
               endcase
            end
         end
         mcss_pkg::ST_WALK: begin
            ctrl.walk_en = 1'b1;
            if (stat.walk_done) state_in = mcss_pkg::ST_LEVEL;
         end
         mcss_pkg::ST_LEVEL: begin
            ctrl.level_rd = 1'b1;
            state_in      = mcss_pkg::ST_SEND;
         end
         mcss_pkg::ST_SEND: begin
            if (stat.out_free) begin
               ctrl.send = 1'b1;
               state_in  = mcss_pkg::ST_IDLE;
            end
         end
         default: state_in = mcss_pkg::ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

>>> src/mcss_dpath.sv
// Datapath of the sampler: CSRs, probability and level memories, row walk
// with running sum, current state and response register. Depends on mcss_pkg.
`default_nettype none

module mcss_dpath #(
   parameter int MAX_STATES = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire mcss_pkg::ctrl_type                ctrl,
   output mcss_pkg::stat_type                     stat,
   input  wire logic [mcss_pkg::ROW_W-1:0]        req_row,
   input  wire logic [mcss_pkg::ROW_W-1:0]        req_column,
   input  wire logic [mcss_pkg::PROB_W-1:0]       req_probability,
   input  wire logic [mcss_pkg::LEVEL_W-1:0]      req_level,
   input  wire logic [mcss_pkg::PROB_W-1:0]       req_uniform,
   input  wire logic                              req_is_step,
   input  wire logic                              csr_valid,
   input  wire logic [mcss_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [mcss_pkg::CSR_DATA_W-1:0]   csr_data,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_valid,
   output logic [mcss_pkg::OUT_IDX_W-1:0]         rsp_state_index,
   output logic [mcss_pkg::LEVEL_W-1:0]           rsp_state_level,
   output logic                                   rsp_fell_short
);

   localparam int IDX_W  = $clog2(MAX_STATES);
   localparam int CNT_W  = $clog2(MAX_STATES + 1);
   localparam int DEPTH  = MAX_STATES * MAX_STATES;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int SUM_W  = mcss_pkg::PROB_W + CNT_W;

   // CSRs
   logic [mcss_pkg::LEVEL_W-1:0] init_ff;
   logic [mcss_pkg::USED_W-1:0]  used_ff;

   // Memories and read registers
   logic [mcss_pkg::PROB_W-1:0]  prob_mem [DEPTH];
   logic [mcss_pkg::LEVEL_W-1:0] level_mem [MAX_STATES];
   logic [mcss_pkg::PROB_W-1:0]  prob_q_ff;
   logic [mcss_pkg::LEVEL_W-1:0] level_q_ff;

   // Walk state
   logic                         is_step_ff;
   logic [mcss_pkg::PROB_W-1:0]  uniform_ff;
   logic [CNT_W-1:0]             issue_ff;
   logic                         pv_ff;
   logic [IDX_W-1:0]             tag_ff;
   logic [SUM_W-1:0]             sum_ff;
   logic [IDX_W-1:0]             cur_ff;
   logic                         short_ff;

   // Response register
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic [mcss_pkg::OUT_IDX_W-1:0] rsp_idx_ff;
   logic [mcss_pkg::LEVEL_W-1:0] rsp_level_ff;
   logic                         rsp_short_ff;

   logic [CNT_W-1:0]             n;
   logic [IDX_W-1:0]             last_idx;
   logic                         row_ok;
   logic                         col_ok;
   logic [ADDR_W-1:0]            prob_waddr;
   logic [ADDR_W-1:0]            prob_raddr;
   logic [IDX_W-1:0]             level_raddr;
   logic                         rd_go;
   logic [SUM_W-1:0]             sum_next;
   logic                         hit;
   logic                         last;
   logic                         out_free;
   logic                         walk_done;

   // Clamp states in use to 1..MAX_STATES
   always_comb begin
      if (used_ff == '0) begin
         n = CNT_W'(1);
      end else if (32'(used_ff) > MAX_STATES) begin
         n = CNT_W'(MAX_STATES);
      end else begin
         n = CNT_W'(used_ff);
      end
   end
   assign last_idx = IDX_W'(n - CNT_W'(1));

   // CSR writes
   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff <= '0;
         used_ff <= mcss_pkg::USED_RESET;
      end else if (csr_valid) begin
         case (mcss_pkg::csr_idx_type'(csr_index))
            mcss_pkg::CSR_INITIAL_VALUE: init_ff <= csr_data;
            mcss_pkg::CSR_STATES_IN_USE: used_ff <= csr_data[mcss_pkg::USED_W-1:0];
            default: ;
         endcase
      end
   end

   // Memory addressing
   assign row_ok      = 32'(req_row) < MAX_STATES;
   assign col_ok      = 32'(req_column) < MAX_STATES;
   assign prob_waddr  = ADDR_W'(32'(req_row) * MAX_STATES + 32'(req_column));
   assign prob_raddr  = ADDR_W'(32'(cur_ff) * MAX_STATES + 32'(issue_ff));
   assign level_raddr = ctrl.walk_en ? issue_ff[IDX_W-1:0] : cur_ff;
   assign rd_go       = ctrl.walk_en && (issue_ff < n);

   // Probability table
   always_ff @(posedge clock) begin
      if (ctrl.load_prob && row_ok && col_ok) prob_mem[prob_waddr] <= req_probability;
      if (rd_go) prob_q_ff <= prob_mem[prob_raddr];
   end

   // Level table
   always_ff @(posedge clock) begin
      if (ctrl.load_level && row_ok) level_mem[IDX_W'(req_row)] <= req_level;
      if (rd_go || ctrl.level_rd) level_q_ff <= level_mem[level_raddr];
   end

   // Compare of the entry read last cycle
   assign sum_next = sum_ff + SUM_W'(prob_q_ff);
   assign hit      = is_step_ff ? (sum_next >= SUM_W'(uniform_ff)) : (level_q_ff == init_ff);
   assign last     = tag_ff == last_idx;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Walk end inside the datapath; the controller only looks at it while walking
   assign walk_done = ctrl.walk_en && pv_ff && (hit || last);

   always_comb begin
      stat.zero_u    = req_uniform == '0;
      stat.walk_done = pv_ff && (hit || last);
      stat.out_free  = out_free;
   end

   // Walk control
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff <= '0;
         pv_ff    <= 1'b0;
      end else if (ctrl.start) begin
         issue_ff <= '0;
         pv_ff    <= 1'b0;
      end else if (ctrl.walk_en) begin
         pv_ff <= rd_go;
         if (rd_go) issue_ff <= issue_ff + CNT_W'(1);
      end
   end

   // Walk payload
   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         is_step_ff <= req_is_step;
         uniform_ff <= req_uniform;
         sum_ff     <= '0;
      end else if (ctrl.walk_en && pv_ff) begin
         sum_ff <= sum_next;
      end
      if (rd_go) tag_ff <= issue_ff[IDX_W-1:0];
   end

   // Current state and short flag
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff   <= '0;
         short_ff <= 1'b0;
      end else if (ctrl.zero_start) begin
         cur_ff   <= '0;
         short_ff <= 1'b0;
      end else if (walk_done) begin
         short_ff <= !hit;
         if (hit) begin
            cur_ff <= tag_ff;
         end else begin
            cur_ff <= is_step_ff ? last_idx : '0;
         end
      end
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.send) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.send) begin
         rsp_idx_ff   <= mcss_pkg::OUT_IDX_W'(cur_ff);
         rsp_level_ff <= level_q_ff;
         rsp_short_ff <= short_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_state_index = rsp_idx_ff;
   assign rsp_state_level = rsp_level_ff;
   assign rsp_fell_short  = rsp_short_ff;

   // Checks
   a_send_free: assert property (@(posedge clock) disable iff (reset)
      ctrl.send |-> out_free)
      else $error("response loaded over a pending one");

   a_send_valid: assert property (@(posedge clock) disable iff (reset)
      ctrl.send |=> rsp_valid_ff)
      else $error("response lost after send");

   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      ctrl.walk_en |-> (issue_ff <= n))
      else $error("walk read past the states in use");

   a_cur_bound: assert property (@(posedge clock) disable iff (reset)
      walk_done |=> (32'(cur_ff) < 32'(n)))
      else $error("selected state outside the states in use");

endmodule

`default_nettype wire

>>> src/markov_chain_state_sampler.sv
// Markov chain state sampler: top level joining controller and datapath.
// Depends on mcss_pkg, mcss_if, mcss_ctrl and mcss_dpath.
//
// Usage:
//   req_ch  valid/ready request: command 0 loads one probability (row, column),
//           1 loads one state level (row), 2 restarts the chain, 3 takes a step
//           with a Q0.16 uniform fraction. Loads finish in the accept cycle and
//           give no response.
//   rsp_ch  valid/ready response for restart and step: new state index, its
//           level and fell_short.
//   csr_ch  register writes (0 initial value, 1 states in use), always ready;
//           write only while no request is in flight.
// Operation: a restart or step walks one table entry per cycle, stopping at the
//   first hit or at the last of the n states in use, then reads the level and
//   sends; a zero-fraction step skips the walk and goes to state 0. One request
//   at a time; the next can be taken in the cycle its response becomes valid.
// Reset clears the CSRs to their defaults, the current state to 0 and the
//   response valid flag; table contents are undefined until loaded.
// A stalled response is held in its output register; the next request is
//   taken once the pending one has been placed there.
`default_nettype none

module markov_chain_state_sampler #(
   parameter int MAX_STATES = 16
) (
   input wire logic  clock,
   input wire logic  reset,
   mcss_req_if.sink  req_ch,
   mcss_rsp_if.source rsp_ch,
   mcss_csr_if.sink  csr_ch
);

   mcss_pkg::ctrl_type ctrl;
   mcss_pkg::stat_type stat;
   logic               req_is_step;

   assign csr_ch.ready = 1'b1;
   assign req_is_step  = mcss_pkg::cmd_type'(req_ch.command) == mcss_pkg::CMD_STEP;

   mcss_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_command (req_ch.command),
      .req_ready   (req_ch.ready),
      .stat        (stat),
      .ctrl        (ctrl)
   );

   mcss_dpath #(
      .MAX_STATES (MAX_STATES)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .stat            (stat),
      .req_row         (req_ch.row),
      .req_column      (req_ch.column),
      .req_probability (req_ch.probability),
      .req_level       (req_ch.level),
      .req_uniform     (req_ch.uniform),
      .req_is_step     (req_is_step),
      .csr_valid       (csr_ch.valid),
      .csr_index       (csr_ch.index),
      .csr_data        (csr_ch.data),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .rsp_state_index (rsp_ch.state_index),
      .rsp_state_level (rsp_ch.state_level),
      .rsp_fell_short  (rsp_ch.fell_short)
   );

endmodule

`default_nettype wire
